@@ hdl/nrr_pkg.sv @@
// ----------------------------------------------------------------------------
// nrr_pkg: shared types and codes
// Event codes, state codes, configuration indexes and beat payload types
// for the node registration retry controller.
// ----------------------------------------------------------------------------
package nrr_pkg;

    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_STOP       = 3'd1;
    localparam logic [2:0] OP_EXPIRE     = 3'd2;
    localparam logic [2:0] OP_RESPONSE   = 3'd3;
    localparam logic [2:0] OP_REREGISTER = 3'd4;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_UNREG = 2'd1;
    localparam logic [1:0] ST_REG   = 2'd2;

    localparam int          CFG_INDEX_W = 3;
    localparam int          CFG_DATA_W  = 48;
    localparam logic [2:0]  CFG_BASE_TIMEOUT   = 3'd0;
    localparam logic [2:0]  CFG_BACKOFF_FACTOR = 3'd1;
    localparam logic [2:0]  CFG_MAX_STEPS      = 3'd2;
    localparam logic [2:0]  CFG_MAX_RETRIES    = 3'd3;
    localparam logic [2:0]  CFG_OWN_MAC        = 3'd4;

    localparam logic [47:0] BCAST_MAC     = {6{8'hFF}};
    localparam logic [3:0]  RETRY_SAT     = 4'hF;
    localparam logic [31:0] TIMEOUT_SAT   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] base_timeout;
        logic [4:0]  backoff_factor;
        logic [3:0]  max_backoff_steps;
        logic [3:0]  max_retries;
        logic [47:0] own_mac;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [47:0] frame_mac;
        logic [15:0] assigned_address;
        logic        timer_ok;
        logic        tx_ok;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  reg_state;
        logic        start_timer;
        logic [31:0] timer_value;
        logic        stop_timer;
        logic        send_request;
        logic        send_confirm;
        logic        address_update;
        logic [15:0] network_address;
        logic        give_up;
        logic [15:0] request_count;
        logic [15:0] response_count;
        logic [15:0] reregister_count;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

endpackage

@@ hdl/nrr_if.sv @@
// ----------------------------------------------------------------------------
// nrr_if: valid/ready channels
// Event channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface nrr_in_if;
    logic             valid;
    logic             ready;
    nrr_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nrr_out_if;
    logic              valid;
    logic              ready;
    nrr_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/nrr_cfg.sv @@
// ----------------------------------------------------------------------------
// nrr_cfg: configuration registers
// Write-only register file with reset values; unused indexes are dropped.
// ----------------------------------------------------------------------------
module nrr_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nrr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nrr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output nrr_pkg::cfg_t                       cfg
);

    nrr_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_timeout      <= 16'd1000;
            cfg_reg.backoff_factor    <= 5'd2;
            cfg_reg.max_backoff_steps <= 4'd4;
            cfg_reg.max_retries       <= 4'd5;
            cfg_reg.own_mac           <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nrr_pkg::CFG_BASE_TIMEOUT:   cfg_reg.base_timeout      <= cfg_data[15:0];
                nrr_pkg::CFG_BACKOFF_FACTOR: cfg_reg.backoff_factor    <= cfg_data[4:0];
                nrr_pkg::CFG_MAX_STEPS:      cfg_reg.max_backoff_steps <= cfg_data[3:0];
                nrr_pkg::CFG_MAX_RETRIES:    cfg_reg.max_retries       <= cfg_data[3:0];
                nrr_pkg::CFG_OWN_MAC:        cfg_reg.own_mac           <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/nrr_inreg.sv @@
// ----------------------------------------------------------------------------
// nrr_inreg: event input register
// Captures one event beat; holds it until the engine takes it.
// ----------------------------------------------------------------------------
module nrr_inreg
(
    input  logic            clk,
    input  logic            rst_n,
    nrr_in_if.sink          events,
    input  logic            take,
    output nrr_pkg::stage_t stage
);

    logic              valid_reg;
    logic              valid_next;
    nrr_pkg::in_item_t item_reg;
    logic              accept;

    assign events.ready = !valid_reg || take;
    assign accept       = events.valid && events.ready;
    assign valid_next   = accept || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= events.payload;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ hdl/nrr_engine.sv @@
// ----------------------------------------------------------------------------
// nrr_engine: registration state machine
// Evaluates one event per cycle, unless the result channel stalls, against
// the held state and loads the result register.
// ----------------------------------------------------------------------------
module nrr_engine
(
    input  logic            clk,
    input  logic            rst_n,
    input  nrr_pkg::cfg_t   cfg,
    input  nrr_pkg::stage_t stage,
    output logic            take,
    nrr_out_if.source       results
);

    typedef enum logic [1:0] {
        S_IDLE  = nrr_pkg::ST_IDLE,
        S_UNREG = nrr_pkg::ST_UNREG,
        S_REG   = nrr_pkg::ST_REG
    } fsm_state_t;

    fsm_state_t         state_reg, state_next;
    logic [3:0]         retry_reg, retry_next;
    logic [31:0]        timeout_reg, timeout_next;
    logic [15:0]        addr_reg, addr_next;
    logic [15:0]        req_cnt_reg, req_cnt_next;
    logic [15:0]        resp_cnt_reg, resp_cnt_next;
    logic [15:0]        rereg_cnt_reg, rereg_cnt_next;
    logic               out_valid_reg;
    nrr_pkg::out_item_t out_reg, out_next;

    nrr_pkg::in_item_t  item;
    logic               try_send;
    logic               mac_own;
    logic [36:0]        prod;

    assign item    = stage.item;
    assign take    = stage.valid && (!out_valid_reg || results.ready);
    assign mac_own = (item.frame_mac == cfg.own_mac);

    always_comb
    begin
        state_next     = state_reg;
        retry_next     = retry_reg;
        timeout_next   = timeout_reg;
        addr_next      = addr_reg;
        req_cnt_next   = req_cnt_reg;
        resp_cnt_next  = resp_cnt_reg;
        rereg_cnt_next = rereg_cnt_reg;
        try_send       = 1'b0;
        prod           = '0;
        out_next       = '0;

        case (item.operation)
            nrr_pkg::OP_START:
            begin
                if (state_reg == S_REG)
                begin
                    out_next.address_update = 1'b1;
                end
                else
                begin
                    state_next   = S_UNREG;
                    retry_next   = '0;
                    timeout_next = {16'd0, cfg.base_timeout};
                    try_send     = 1'b1;
                end
            end
            nrr_pkg::OP_STOP:
            begin
                if (state_reg != S_IDLE)
                begin
                    retry_next          = '0;
                    timeout_next        = {16'd0, cfg.base_timeout};
                    out_next.stop_timer = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            nrr_pkg::OP_EXPIRE:
            begin
                if (retry_reg >= cfg.max_retries)
                begin
                    retry_next       = '0;
                    timeout_next     = {16'd0, cfg.base_timeout};
                    state_next       = S_IDLE;
                    out_next.give_up = 1'b1;
                end
                else
                begin
                    try_send = 1'b1;
                end
            end
            nrr_pkg::OP_RESPONSE:
            begin
                if (mac_own)
                begin
                    out_next.stop_timer     = 1'b1;
                    resp_cnt_next           = resp_cnt_reg + 16'd1;
                    addr_next               = item.assigned_address;
                    out_next.address_update = 1'b1;
                    out_next.send_confirm   = 1'b1;
                    state_next              = S_REG;
                end
            end
            nrr_pkg::OP_REREGISTER:
            begin
                if (state_reg != S_IDLE && (mac_own || item.frame_mac == nrr_pkg::BCAST_MAC))
                begin
                    rereg_cnt_next = rereg_cnt_reg + 16'd1;
                    state_next     = S_UNREG;
                    retry_next     = '0;
                    timeout_next   = {16'd0, cfg.base_timeout};
                    try_send       = 1'b1;
                end
            end
            default: ;
        endcase

        if (try_send && state_next == S_UNREG && item.timer_ok)
        begin
            out_next.start_timer  = 1'b1;
            out_next.timer_value  = timeout_next;
            out_next.send_request = 1'b1;
            if (item.tx_ok)
            begin
                req_cnt_next = req_cnt_reg + 16'd1;
                if (retry_next < cfg.max_backoff_steps)
                begin
                    prod = {5'd0, timeout_next} * {32'd0, cfg.backoff_factor};
                    timeout_next = (prod[36:32] != 5'd0) ? nrr_pkg::TIMEOUT_SAT : prod[31:0];
                end
                if (retry_next != nrr_pkg::RETRY_SAT)
                begin
                    retry_next = retry_next + 4'd1;
                end
            end
        end

        out_next.reg_state        = state_next;
        out_next.network_address  = addr_next;
        out_next.request_count    = req_cnt_next;
        out_next.response_count   = resp_cnt_next;
        out_next.reregister_count = rereg_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            retry_reg     <= '0;
            timeout_reg   <= '0;
            addr_reg      <= '0;
            req_cnt_reg   <= '0;
            resp_cnt_reg  <= '0;
            rereg_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (take)
            begin
                state_reg     <= state_next;
                retry_reg     <= retry_next;
                timeout_reg   <= timeout_next;
                addr_reg      <= addr_next;
                req_cnt_reg   <= req_cnt_next;
                resp_cnt_reg  <= resp_cnt_next;
                rereg_cnt_reg <= rereg_cnt_next;
                out_reg       <= out_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

endmodule

@@ hdl/node_registration_retry_fsm.sv @@
// ----------------------------------------------------------------------------
// Path: an event beat is captured in the input register, then evaluated into
// the result register, from which its result beat is taken.
// Throughput: one event per cycle unless results stall; the state update, the
// 32x5 backoff multiply and the saturation fit in the single stage between
// the registers. Reset: state idle, counters, address and timeout cleared,
// registers at their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// node_registration_retry_fsm: node registration retry controller
// Tracks idle, unregistered and registered, drives request retries with
// timeout backoff, and reports one result beat per event beat.
// ----------------------------------------------------------------------------
module node_registration_retry_fsm
(
    input  logic                            clk,
    input  logic                            rst_n,
    nrr_in_if.sink                          events,
    nrr_out_if.source                       results,
    input  logic                            cfg_we,
    input  logic [nrr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [nrr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    nrr_pkg::cfg_t   cfg;
    nrr_pkg::stage_t stage;
    logic            take;

    nrr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nrr_inreg u_inreg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .events (events),
        .take   (take),
        .stage  (stage)
    );

    nrr_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .stage   (stage),
        .take    (take),
        .results (results)
    );

endmodule

@@ hdl/nrr_checker.sv @@
// ----------------------------------------------------------------------------
// nrr_checker: port-level checks
// Watches the result channel of the top level for consistent beats.
// ----------------------------------------------------------------------------
module nrr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input nrr_pkg::out_item_t res
);

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.start_timer |-> res.timer_value == 32'd0)
    else $error("timer value without timer start");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.give_up |-> res.reg_state == nrr_pkg::ST_IDLE && !res.start_timer)
    else $error("give up outside idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.send_confirm
            |-> res.reg_state == nrr_pkg::ST_REG && res.address_update && res.stop_timer)
    else $error("confirm without registration");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.send_request |-> res.reg_state == nrr_pkg::ST_UNREG && res.start_timer)
    else $error("request outside unregistered");

endmodule

bind node_registration_retry_fsm nrr_checker u_nrr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res       (results.payload)
);
